[hw/rtl/rurc_pkg.sv]
// ----------------------------------------------------------------------------
// rurc_pkg
// Shared types, constants and helpers of the datagram connection receiver.
// ----------------------------------------------------------------------------
package rurc_pkg;

  // Default largest payload taken per packet (longer payloads are truncated)
  localparam int unsigned MaxPayloadDef = 1024;

  // Configuration register reset values
  localparam logic [15:0] WindowRst = 16'hFFFF;
  localparam logic [15:0] ResendRst = 16'd5000;

  // APB address width: two 32-bit registers at byte offsets 0 and 4
  localparam int unsigned PaddrW = 3;

  // Result queue geometry
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  // Register indexes
  typedef enum logic {
    REG_WINDOW = 1'b0,
    REG_RESEND = 1'b1
  } reg_idx_e;

  // Connection phases
  typedef enum logic [2:0] {
    PH_WAIT_SYN    = 3'd0,
    PH_WAIT_ACK    = 3'd1,
    PH_DATA        = 3'd2,
    PH_WAIT_FINACK = 3'd3,
    PH_CLOSED      = 3'd4
  } phase_e;

  // Input opcodes
  typedef enum logic {
    OP_PACKET = 1'b0,
    OP_TICK   = 1'b1
  } opcode_e;

  typedef struct packed {
    logic [15:0] window;
    logic [15:0] resend;
  } cfg_t;

  typedef struct packed {
    logic        opcode;
    logic        has_syn;
    logic        has_ack;
    logic        has_fin;
    logic [31:0] pkt_seq;
    logic [31:0] pkt_ack;
    logic [10:0] payload_len;
    logic        drop_request;
    logic [31:0] fresh_isn;
  } req_t;

  typedef struct packed {
    logic        out_syn;
    logic        out_ack;
    logic        out_fin;
    logic [31:0] out_seq;
    logic [31:0] out_ack_num;
    logic [15:0] out_window;
    logic        payload_accepted;
    logic [2:0]  conn_phase;
    logic        last_result;
  } res_t;

  // Results produced by one request, handed to the result queue
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic res_t make_res(
    input logic        syn,
    input logic        ack,
    input logic        fin,
    input logic [31:0] seq,
    input logic [31:0] ackn,
    input logic [15:0] window,
    input logic        acc,
    input phase_e      ph,
    input logic        last
  );
    res_t r;
    r.out_syn          = syn;
    r.out_ack          = ack;
    r.out_fin          = fin;
    r.out_seq          = seq;
    r.out_ack_num      = ackn;
    r.out_window       = window;
    r.payload_accepted = acc;
    r.conn_phase       = ph;
    r.last_result      = last;
    return r;
  endfunction

endpackage

[hw/rtl/rurc_req_if.sv]
// ----------------------------------------------------------------------------
// rurc_req_if
// Request channel: decoded packet header or timer tick, valid/ready.
// ----------------------------------------------------------------------------
interface rurc_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic        has_syn;
  logic        has_ack;
  logic        has_fin;
  logic [31:0] pkt_seq;
  logic [31:0] pkt_ack;
  logic [10:0] payload_len;
  logic        drop_request;
  logic [31:0] fresh_isn;

  modport source (
    output valid, opcode, has_syn, has_ack, has_fin, pkt_seq, pkt_ack,
           payload_len, drop_request, fresh_isn,
    input  ready
  );

  modport sink (
    input  valid, opcode, has_syn, has_ack, has_fin, pkt_seq, pkt_ack,
           payload_len, drop_request, fresh_isn,
    output ready
  );
endinterface

[hw/rtl/rurc_res_if.sv]
// ----------------------------------------------------------------------------
// rurc_res_if
// Result channel: header of one packet to send, valid/ready.
// ----------------------------------------------------------------------------
interface rurc_res_if;
  logic        valid;
  logic        ready;
  logic        out_syn;
  logic        out_ack;
  logic        out_fin;
  logic [31:0] out_seq;
  logic [31:0] out_ack_num;
  logic [15:0] out_window;
  logic        payload_accepted;
  logic [2:0]  conn_phase;
  logic        last_result;

  modport source (
    output valid, out_syn, out_ack, out_fin, out_seq, out_ack_num, out_window,
           payload_accepted, conn_phase, last_result,
    input  ready
  );

  modport sink (
    input  valid, out_syn, out_ack, out_fin, out_seq, out_ack_num, out_window,
           payload_accepted, conn_phase, last_result,
    output ready
  );
endinterface

[hw/rtl/rurc_cfg.sv]
// ----------------------------------------------------------------------------
// rurc_cfg
// APB register file: advertised window and resend tick count.
// ----------------------------------------------------------------------------
module rurc_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rurc_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output rurc_pkg::cfg_t              cfg_o
);

  logic [15:0]        window_q, window_d;
  logic [15:0]        resend_q, resend_d;
  logic               wr_en;
  rurc_pkg::reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = rurc_pkg::reg_idx_e'(paddr[2]);

  // Decode writes
  always_comb begin
    window_d = window_q;
    resend_d = resend_q;
    if (wr_en) begin
      unique case (idx)
        rurc_pkg::REG_WINDOW: window_d = pwdata[15:0];
        rurc_pkg::REG_RESEND: resend_d = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= rurc_pkg::WindowRst;
      resend_q <= rurc_pkg::ResendRst;
    end else begin
      window_q <= window_d;
      resend_q <= resend_d;
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      rurc_pkg::REG_WINDOW: prdata = {16'd0, window_q};
      rurc_pkg::REG_RESEND: prdata = {16'd0, resend_q};
      default:              prdata = 32'd0;
    endcase
  end

  assign cfg_o.window = window_q;
  assign cfg_o.resend = resend_q;

endmodule

[hw/rtl/rurc_core.sv]
// ----------------------------------------------------------------------------
// rurc_core
// Request register and connection state machine; builds up to two result
// headers per request and pushes them into the result queue.
// ----------------------------------------------------------------------------
module rurc_core #(
  parameter int unsigned MaxPayload = rurc_pkg::MaxPayloadDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  rurc_req_if.sink            req_i,
  input  rurc_pkg::cfg_t      cfg_i,
  input  logic                room_i,
  output rurc_pkg::push_t     push_o
);

  logic              stg_valid_q, stg_valid_d;
  rurc_pkg::req_t    stg_q;
  logic              accept;
  logic              adv;

  rurc_pkg::phase_e  phase_q, phase_d;
  logic [31:0]       next_exp_q, next_exp_d;
  logic [31:0]       own_seq_q, own_seq_d;
  logic [15:0]       idle_q, idle_d;

  logic [15:0]       idle_inc;
  logic [15:0]       limit;
  logic              expired;
  logic [31:0]       len_raw;
  logic [31:0]       len_max;
  logic [31:0]       len_w;
  logic              is_tick;
  logic              ack_match;

  // Request register: refill when empty or when its item moves on
  assign adv         = stg_valid_q && room_i;
  assign req_i.ready = !stg_valid_q || room_i;
  assign accept      = req_i.valid && req_i.ready;
  assign stg_valid_d = accept ? 1'b1 : (adv ? 1'b0 : stg_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_q.opcode       <= req_i.opcode;
      stg_q.has_syn      <= req_i.has_syn;
      stg_q.has_ack      <= req_i.has_ack;
      stg_q.has_fin      <= req_i.has_fin;
      stg_q.pkt_seq      <= req_i.pkt_seq;
      stg_q.pkt_ack      <= req_i.pkt_ack;
      stg_q.payload_len  <= req_i.payload_len;
      stg_q.drop_request <= req_i.drop_request;
      stg_q.fresh_isn    <= req_i.fresh_isn;
    end
  end

  // Resend timer: a zero count acts as one
  assign idle_inc = idle_q + 16'd1;
  assign limit    = (cfg_i.resend == 16'd0) ? 16'd1 : cfg_i.resend;
  assign expired  = idle_inc >= limit;

  // Truncate oversized payloads
  assign len_raw = {21'd0, stg_q.payload_len};
  assign len_max = 32'(MaxPayload);
  assign len_w   = (len_raw > len_max) ? len_max : len_raw;

  assign is_tick   = stg_q.opcode == rurc_pkg::OP_TICK;
  assign ack_match = stg_q.has_ack && (stg_q.pkt_ack == own_seq_q + 32'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= rurc_pkg::PH_WAIT_SYN;
      next_exp_q <= 32'd0;
      own_seq_q  <= 32'd0;
      idle_q     <= 16'd0;
    end else begin
      phase_q    <= phase_d;
      next_exp_q <= next_exp_d;
      own_seq_q  <= own_seq_d;
      idle_q     <= idle_d;
    end
  end

  // Next state and result headers
  always_comb begin
    phase_d     = phase_q;
    next_exp_d  = next_exp_q;
    own_seq_d   = own_seq_q;
    idle_d      = idle_q;
    push_o.cnt  = 2'd0;
    push_o.r0   = '0;
    push_o.r1   = '0;
    if (adv) begin
      unique case (phase_q)
        rurc_pkg::PH_WAIT_SYN: begin
          if (!is_tick && stg_q.has_syn) begin
            next_exp_d = stg_q.pkt_seq + 32'd1;
            own_seq_d  = stg_q.fresh_isn;
            idle_d     = 16'd0;
            phase_d    = rurc_pkg::PH_WAIT_ACK;
            push_o.cnt = 2'd1;
            push_o.r0  = rurc_pkg::make_res(1'b1, 1'b1, 1'b0, stg_q.fresh_isn,
                           stg_q.pkt_seq + 32'd1, cfg_i.window, 1'b0,
                           rurc_pkg::PH_WAIT_ACK, 1'b1);
          end
        end
        rurc_pkg::PH_WAIT_ACK: begin
          if (is_tick) begin
            idle_d = expired ? 16'd0 : idle_inc;
            if (expired) begin
              push_o.cnt = 2'd1;
              push_o.r0  = rurc_pkg::make_res(1'b1, 1'b1, 1'b0, own_seq_q,
                             next_exp_q, cfg_i.window, 1'b0, phase_q, 1'b1);
            end
          end else begin
            idle_d = 16'd0;
            if (ack_match) begin
              phase_d = rurc_pkg::PH_DATA;
            end
          end
        end
        rurc_pkg::PH_DATA: begin
          if (!is_tick) begin
            if (stg_q.has_fin) begin
              // Teardown: ACK the FIN, then send our own FIN
              own_seq_d  = stg_q.fresh_isn;
              idle_d     = 16'd0;
              phase_d    = rurc_pkg::PH_WAIT_FINACK;
              push_o.cnt = 2'd2;
              push_o.r0  = rurc_pkg::make_res(1'b0, 1'b1, 1'b0, 32'd0,
                             stg_q.pkt_seq + 32'd1, cfg_i.window, 1'b0,
                             rurc_pkg::PH_WAIT_FINACK, 1'b0);
              push_o.r1  = rurc_pkg::make_res(1'b0, 1'b0, 1'b1, stg_q.fresh_isn,
                             32'd0, cfg_i.window, 1'b0,
                             rurc_pkg::PH_WAIT_FINACK, 1'b1);
            end else if (stg_q.payload_len != 11'd0 && !stg_q.drop_request) begin
              // Cumulative ACK; advance only on the in-order payload
              push_o.cnt = 2'd1;
              if (stg_q.pkt_seq == next_exp_q) begin
                next_exp_d = next_exp_q + len_w;
                push_o.r0  = rurc_pkg::make_res(1'b0, 1'b1, 1'b0, 32'd0,
                               next_exp_q + len_w, cfg_i.window, 1'b1,
                               phase_q, 1'b1);
              end else begin
                push_o.r0  = rurc_pkg::make_res(1'b0, 1'b1, 1'b0, 32'd0,
                               next_exp_q, cfg_i.window, 1'b0, phase_q, 1'b1);
              end
            end
          end
        end
        rurc_pkg::PH_WAIT_FINACK: begin
          if (is_tick) begin
            idle_d = expired ? 16'd0 : idle_inc;
            if (expired) begin
              push_o.cnt = 2'd1;
              push_o.r0  = rurc_pkg::make_res(1'b0, 1'b0, 1'b1, own_seq_q,
                             32'd0, cfg_i.window, 1'b0, phase_q, 1'b1);
            end
          end else begin
            idle_d = 16'd0;
            if (ack_match) begin
              phase_d = rurc_pkg::PH_CLOSED;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Two results come only from the FIN that starts teardown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.cnt == 2'd2 |=> phase_q == rurc_pkg::PH_WAIT_FINACK)
    else $error("double push without entering FIN wait");

  // Results are pushed only when the registered request advances
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.cnt != 2'd0 |-> adv)
    else $error("push without advancing request");

  // Connection state holds while no request advances
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(next_exp_q) && $stable(own_seq_q) && $stable(phase_q))
    else $error("state changed without a request");

  // A request held back by a full queue stays in place
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_valid_q && !room_i |=> stg_valid_q && $stable(stg_q))
    else $error("stalled request lost");

endmodule

[hw/rtl/rurc_resq.sv]
// ----------------------------------------------------------------------------
// rurc_resq
// Small result queue: up to two headers in a cycle; one out a cycle if ready.
// ----------------------------------------------------------------------------
module rurc_resq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rurc_pkg::push_t push_i,
  output logic            room_o,
  rurc_res_if.source      res_o
);

  rurc_pkg::res_t                mem_q [rurc_pkg::QDepth];
  logic [rurc_pkg::QPtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [rurc_pkg::QPtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [rurc_pkg::QCntW-1:0]    cnt_q, cnt_d;
  logic [rurc_pkg::QPtrW-1:0]    wr_ptr_nx;
  logic                          pop;
  rurc_pkg::res_t                head;

  // Room for a worst-case request of two results
  assign room_o    = cnt_q <= rurc_pkg::QCntW'(rurc_pkg::QDepth - 2);
  assign pop       = res_o.valid && res_o.ready;
  assign wr_ptr_nx = wr_ptr_q + rurc_pkg::QPtrW'(1);

  assign wr_ptr_d = wr_ptr_q + rurc_pkg::QPtrW'(push_i.cnt);
  assign rd_ptr_d = pop ? rd_ptr_q + rurc_pkg::QPtrW'(1) : rd_ptr_q;
  assign cnt_d    = cnt_q + rurc_pkg::QCntW'(push_i.cnt) - rurc_pkg::QCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store pushed headers
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.r1;
    end
  end

  // Drive head of queue
  assign head                   = mem_q[rd_ptr_q];
  assign res_o.valid            = cnt_q != '0;
  assign res_o.out_syn          = head.out_syn;
  assign res_o.out_ack          = head.out_ack;
  assign res_o.out_fin          = head.out_fin;
  assign res_o.out_seq          = head.out_seq;
  assign res_o.out_ack_num      = head.out_ack_num;
  assign res_o.out_window       = head.out_window;
  assign res_o.payload_accepted = head.payload_accepted;
  assign res_o.conn_phase       = head.conn_phase;
  assign res_o.last_result      = head.last_result;

endmodule

[hw/rtl/reliable_udp_receiver_connection_top.sv]
// ----------------------------------------------------------------------------
// reliable_udp_receiver_connection_top
// Receiver side of a datagram connection: handshake, in-order data, teardown.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one decoded packet header or one timer tick per request
//   (valid/ready). res_o carries the headers to send, one per transfer on the
//   result channel; last_result marks the final header of a request (a FIN
//   in the data phase yields an ACK and then our own FIN).
//   The APB port sets the advertised window and the resend tick count; write
//   it only while no request is in flight.
// Timing:
//   A request is registered on acceptance and its headers are then written
//   into the result queue, whose head drives res_o. One request is taken
//   per cycle while the queue has room; a request with two headers takes
//   two transfers on res_o. The four-entry result queue sets the rate: a
//   request waits in its register until two entries are free.
// Reset and stalls:
//   Reset puts the connection in the wait-for-SYN phase and empties the
//   queue. When res_o is stalled the queue fills and req_i.ready drops;
//   nothing is lost.
// ----------------------------------------------------------------------------
module reliable_udp_receiver_connection_top #(
  parameter int unsigned MaxPayload = rurc_pkg::MaxPayloadDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  rurc_req_if.sink                    req_i,
  rurc_res_if.source                  res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rurc_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  rurc_pkg::cfg_t  cfg;
  rurc_pkg::push_t push;
  logic            room;

  rurc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rurc_core #(
    .MaxPayload (MaxPayload)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cfg_i  (cfg),
    .room_i (room),
    .push_o (push)
  );

  rurc_resq u_resq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .res_o  (res_o)
  );

endmodule
